>>> hdl/sample_frame_builder_crc32_core_defines.svh
// Assertion macros used by the frame builder core.
`ifndef SAMPLE_FRAME_BUILDER_CRC32_CORE_DEFINES_SVH
`define SAMPLE_FRAME_BUILDER_CRC32_CORE_DEFINES_SVH

// Same-cycle implication, sampled on clk_i, held off during reset.
`define SFB_ASSERT_IMPLY(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("sfb: same-cycle check failed");

// Next-cycle implication, sampled on clk_i, held off during reset.
`define SFB_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("sfb: next-cycle check failed");

`endif

>>> hdl/sfb_pkg.sv
package sfb_pkg;

  localparam int unsigned MaxPayload  = 4096;
  localparam int unsigned HeaderBytes = 30;
  localparam int unsigned CrcBytes    = 4;
  localparam int unsigned CntW        = 6;
  localparam int unsigned CfgIdxW     = 4;

  localparam logic [31:0] CrcPoly = 32'hedb88320;
  localparam logic [31:0] CrcInit = 32'hffffffff;

  typedef enum logic {
    FUNC_START = 1'b0,
    FUNC_DATA  = 1'b1
  } func_e;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_TOO_LONG = 2'd1,
    ST_OPEN     = 2'd2,
    ST_STRAY    = 2'd3
  } status_e;

  typedef enum logic [CfgIdxW-1:0] {
    REG_MAGIC   = 4'd0,
    REG_VERSION = 4'd1,
    REG_TYPE    = 4'd2,
    REG_SOURCE  = 4'd3,
    REG_MASK    = 4'd4,
    REG_RATE    = 4'd5,
    REG_STEP    = 4'd6,
    REG_FORMAT  = 4'd7
  } cfg_idx_e;

  typedef struct packed {
    logic [15:0] frame_magic;
    logic [7:0]  frame_version;
    logic [7:0]  frame_type;
    logic [7:0]  source_id;
    logic [15:0] channel_mask;
    logic [31:0] sample_rate_hz;
    logic [31:0] step_ns;
    logic [7:0]  sample_format;
  } cfg_t;

  localparam cfg_t CfgReset = '{
    frame_magic:    16'd0,
    frame_version:  8'd1,
    frame_type:     8'd0,
    source_id:      8'd0,
    channel_mask:   16'd0,
    sample_rate_hz: 32'd0,
    step_ns:        32'd0,
    sample_format:  8'd0
  };

  function automatic logic [31:0] crc_byte(logic [31:0] crc, logic [7:0] b);
    logic [31:0] c;
    c = crc ^ {24'd0, b};
    for (int k = 0; k < 8; k++) begin
      c = (c >> 1) ^ (CrcPoly & {32{c[0]}});
    end
    return c;
  endfunction

  function automatic logic [7:0] header_byte(logic [4:0] idx, cfg_t cfg, logic [31:0] seq,
                                             logic [63:0] t0, logic [15:0] count);
    logic [7:0] b;
    unique case (idx)
      5'd0:  b = cfg.frame_magic[7:0];
      5'd1:  b = cfg.frame_magic[15:8];
      5'd2:  b = cfg.frame_version;
      5'd3:  b = cfg.frame_type;
      5'd4:  b = seq[7:0];
      5'd5:  b = seq[15:8];
      5'd6:  b = seq[23:16];
      5'd7:  b = seq[31:24];
      5'd8:  b = cfg.source_id;
      5'd9:  b = cfg.channel_mask[7:0];
      5'd10: b = cfg.channel_mask[15:8];
      5'd11: b = cfg.sample_rate_hz[7:0];
      5'd12: b = cfg.sample_rate_hz[15:8];
      5'd13: b = cfg.sample_rate_hz[23:16];
      5'd14: b = cfg.sample_rate_hz[31:24];
      5'd15: b = t0[7:0];
      5'd16: b = t0[15:8];
      5'd17: b = t0[23:16];
      5'd18: b = t0[31:24];
      5'd19: b = t0[39:32];
      5'd20: b = t0[47:40];
      5'd21: b = t0[55:48];
      5'd22: b = t0[63:56];
      5'd23: b = cfg.step_ns[7:0];
      5'd24: b = cfg.step_ns[15:8];
      5'd25: b = cfg.step_ns[23:16];
      5'd26: b = cfg.step_ns[31:24];
      5'd27: b = cfg.sample_format;
      5'd28: b = count[7:0];
      5'd29: b = count[15:8];
      default: b = 8'd0;
    endcase
    return b;
  endfunction

endpackage

>>> hdl/sfb_if.sv
interface sfb_in_if;
  logic        valid;
  logic        ready;
  logic        func;
  logic [63:0] start_time_us;
  logic [15:0] sample_count;
  logic [15:0] payload_bytes;
  logic [7:0]  data_byte;

  modport source (output valid, func, start_time_us, sample_count, payload_bytes, data_byte,
                  input ready);
  modport sink   (input valid, func, start_time_us, sample_count, payload_bytes, data_byte,
                  output ready);
endinterface

interface sfb_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       last;
  logic [1:0] status;

  modport source (output valid, out_byte, last, status, input ready);
  modport sink   (input valid, out_byte, last, status, output ready);
endinterface

interface sfb_cfg_if;
  logic                        valid;
  logic                        ready;
  logic [sfb_pkg::CfgIdxW-1:0] index;
  logic [31:0]                 data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

>>> hdl/sfb_cfg_regs.sv
module sfb_cfg_regs (
  input  logic          clk_i,
  input  logic          rst_ni,
  sfb_cfg_if.sink       cfg_i,
  output sfb_pkg::cfg_t cfg_o
);

  sfb_pkg::cfg_t cfg_q, cfg_d;

  assign cfg_i.ready = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_i.valid) begin
      unique case (cfg_i.index)
        sfb_pkg::REG_MAGIC:   cfg_d.frame_magic    = cfg_i.data[15:0];
        sfb_pkg::REG_VERSION: cfg_d.frame_version  = cfg_i.data[7:0];
        sfb_pkg::REG_TYPE:    cfg_d.frame_type     = cfg_i.data[7:0];
        sfb_pkg::REG_SOURCE:  cfg_d.source_id      = cfg_i.data[7:0];
        sfb_pkg::REG_MASK:    cfg_d.channel_mask   = cfg_i.data[15:0];
        sfb_pkg::REG_RATE:    cfg_d.sample_rate_hz = cfg_i.data;
        sfb_pkg::REG_STEP:    cfg_d.step_ns        = cfg_i.data;
        sfb_pkg::REG_FORMAT:  cfg_d.sample_format  = cfg_i.data[7:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= sfb_pkg::CfgReset;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

>>> hdl/sample_frame_builder_crc32_core.sv
// Channel    Role    Payload
// in_chan_i  sink    func, start_time_us, sample_count, payload_bytes, data_byte
// out_chan_o source  out_byte, last, status
// cfg_i      sink    index, data (always ready)
//
// The last payload byte is followed by the CRC trailer; an error answer is one status beat.
// A start item sends the 30-byte header, then the CRC trailer if the payload is empty.
// One byte leaves the job register per cycle into the output register; that port sets the rate.
// The next item is taken in the cycle the current job emits its final byte.
// Reset is asynchronous and clears sequence, CRC, frame state and configuration.
// A stalled output holds the job; input ready drops until the job can finish.
`include "sample_frame_builder_crc32_core_defines.svh"

module sample_frame_builder_crc32_core (
  input  logic      clk_i,
  input  logic      rst_ni,
  sfb_in_if.sink    in_chan_i,
  sfb_out_if.source out_chan_o,
  sfb_cfg_if.sink   cfg_i
);

  localparam logic [sfb_pkg::CntW-1:0] HdrLast = sfb_pkg::CntW'(sfb_pkg::HeaderBytes - 1);
  localparam logic [sfb_pkg::CntW-1:0] HdrEnd  = sfb_pkg::CntW'(sfb_pkg::HeaderBytes);
  localparam logic [sfb_pkg::CntW-1:0] CntMax  =
    sfb_pkg::CntW'(sfb_pkg::HeaderBytes + sfb_pkg::CrcBytes - 1);
  localparam logic [15:0] MaxLen = 16'(sfb_pkg::MaxPayload);

  sfb_pkg::cfg_t cfg;

  sfb_cfg_regs u_cfg (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_i),
    .cfg_o  (cfg)
  );

  logic                      job_valid_q;
  sfb_pkg::func_e            job_func_q;
  logic [63:0]               job_t0_q;
  logic [15:0]               job_count_q;
  logic [15:0]               job_plen_q;
  logic [7:0]                job_data_q;
  logic [sfb_pkg::CntW-1:0]  cnt_q;

  logic [31:0] seq_q, seq_d;
  logic [31:0] crc_q, crc_d;
  logic        open_q, open_d;
  logic [15:0] rem_q, rem_d;

  logic             out_valid_q;
  logic [7:0]       out_byte_q, out_byte_d;
  logic             out_last_q, out_last_d;
  sfb_pkg::status_e out_status_q, out_status_d;

  logic       step, done, accept, crc_end;
  logic [1:0] crc_sel;
  logic [31:0] crc_out;

  assign step    = job_valid_q && (!out_valid_q || out_chan_o.ready);
  assign accept  = in_chan_i.valid && in_chan_i.ready;
  assign crc_out = ~crc_q;

  assign in_chan_i.ready = !job_valid_q || (step && done);

  always_comb begin
    out_byte_d   = 8'd0;
    out_last_d   = 1'b0;
    out_status_d = sfb_pkg::ST_OK;
    done         = 1'b1;
    crc_end      = 1'b0;
    crc_sel      = 2'd0;
    seq_d        = seq_q;
    crc_d        = crc_q;
    open_d       = open_q;
    rem_d        = rem_q;
    if (job_func_q == sfb_pkg::FUNC_START) begin
      if (open_q) begin
        out_status_d = sfb_pkg::ST_OPEN;
      end else if (job_plen_q > MaxLen) begin
        out_status_d = sfb_pkg::ST_TOO_LONG;
      end else if (cnt_q < HdrEnd) begin
        out_byte_d = sfb_pkg::header_byte(cnt_q[4:0], cfg, seq_q, job_t0_q, job_count_q);
        if (cnt_q >= sfb_pkg::CntW'(2)) begin
          crc_d = sfb_pkg::crc_byte(crc_q, out_byte_d);
        end
        done = 1'b0;
        if (cnt_q == HdrLast) begin
          seq_d = seq_q + 32'd1;
          if (job_plen_q != 16'd0) begin
            done   = 1'b1;
            open_d = 1'b1;
            rem_d  = job_plen_q;
          end
        end
      end else begin
        crc_sel = 2'(cnt_q - HdrEnd);
        crc_end = 1'b1;
      end
    end else begin
      if (!open_q) begin
        out_status_d = sfb_pkg::ST_STRAY;
      end else if (cnt_q == '0) begin
        out_byte_d = job_data_q;
        crc_d      = sfb_pkg::crc_byte(crc_q, job_data_q);
        rem_d      = rem_q - 16'd1;
        done       = (rem_q != 16'd1);
      end else begin
        crc_sel = 2'(cnt_q - sfb_pkg::CntW'(1));
        crc_end = 1'b1;
      end
    end
    if (crc_end) begin
      out_byte_d = crc_out[8*crc_sel +: 8];
      out_last_d = (crc_sel == 2'd3);
      done       = out_last_d;
      if (out_last_d) begin
        open_d = 1'b0;
        rem_d  = 16'd0;
        crc_d  = sfb_pkg::CrcInit;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      job_valid_q <= 1'b0;
      cnt_q       <= '0;
      seq_q       <= '0;
      crc_q       <= sfb_pkg::CrcInit;
      open_q      <= 1'b0;
      rem_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (step) begin
        seq_q  <= seq_d;
        crc_q  <= crc_d;
        open_q <= open_d;
        rem_q  <= rem_d;
      end
      if (accept) begin
        job_valid_q <= 1'b1;
        cnt_q       <= '0;
      end else if (step) begin
        cnt_q <= cnt_q + sfb_pkg::CntW'(1);
        if (done) begin
          job_valid_q <= 1'b0;
        end
      end
      if (step) begin
        out_valid_q <= 1'b1;
      end else if (out_chan_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      job_func_q  <= sfb_pkg::func_e'(in_chan_i.func);
      job_t0_q    <= in_chan_i.start_time_us;
      job_count_q <= in_chan_i.sample_count;
      job_plen_q  <= in_chan_i.payload_bytes;
      job_data_q  <= in_chan_i.data_byte;
    end
    if (step) begin
      out_byte_q   <= out_byte_d;
      out_last_q   <= out_last_d;
      out_status_q <= out_status_d;
    end
  end

  assign out_chan_o.valid    = out_valid_q;
  assign out_chan_o.out_byte = out_byte_q;
  assign out_chan_o.last     = out_last_q;
  assign out_chan_o.status   = out_status_q;

  `SFB_ASSERT_IMPLY(a_cnt_range, job_valid_q, cnt_q <= CntMax)
  `SFB_ASSERT_IMPLY(a_open_has_rem, open_q && !job_valid_q, rem_q != 16'd0)
  `SFB_ASSERT_IMPLY(a_idle_crc_init, !open_q && !job_valid_q, crc_q == sfb_pkg::CrcInit)
  `SFB_ASSERT_NEXT(a_trailer_closes, step && crc_end && out_last_d,
                   !open_q && crc_q == sfb_pkg::CrcInit && out_last_q)

endmodule
